// File: src/gpll_pkg.sv
// ----------------------------------------------------------------------------
// Grid phase-locked loop package
// Shared constants, register indexes, reset values and the quarter-wave sine
// entry generator used to build the phase rotation table.
// ----------------------------------------------------------------------------
package gpll_pkg;

	// Default widths of the phase accumulator, the samples and the sine table.
	localparam int unsigned PHASE_BITS_DEF      = 32;
	localparam int unsigned SAMPLE_BITS_DEF     = 16;
	localparam int unsigned SINE_TABLE_BITS_DEF = 10;

	// Fixed field widths.
	localparam int unsigned SPEED_W    = 22;
	localparam int unsigned GAIN_W     = 32;
	localparam int unsigned QLIM_W     = 15;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned SINE_W     = 15;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN       = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN_STEP = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX       = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_MIN       = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_INITIAL   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_Q_LIMIT    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_SPEED_LOW  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_SPEED_HIGH = 4'd7;

	// Register values after reset.
	localparam logic [SPEED_W-1:0] SPEED_MAX_RST       = 22'd1503238;
	localparam logic [SPEED_W-1:0] SPEED_MIN_RST       = 22'd966367;
	localparam logic [SPEED_W-1:0] SPEED_INITIAL_RST   = 22'd1073742;
	localparam logic [QLIM_W-1:0]  LOCK_Q_LIMIT_RST    = 15'd400;
	localparam logic [SPEED_W-1:0] LOCK_SPEED_LOW_RST  = 22'd1020054;
	localparam logic [SPEED_W-1:0] LOCK_SPEED_HIGH_RST = 22'd1127427;

	// Clarke transform weights in Q16: one third and one over root three.
	localparam logic signed [16:0] CLARKE_ALPHA = 17'sd21845;
	localparam logic signed [16:0] CLARKE_BETA  = 17'sd37837;

	// Full-scale sine value in Q15.
	localparam logic signed [16:0] SINE_FULL = 17'sd32767;

	// A quarter turn in Q30.
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

	// Unsigned long division by shift and subtract, giving the floor quotient.
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] dv);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], n[b]};
			if (rem >= dv) begin
				rem = rem - dv;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// One entry of the quarter-wave table: sin(pi/2 * i / 2^tbits) in Q15,
	// evaluated by a nested Taylor series in Q30.
	function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i,
			input int unsigned tbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] e;
		logic [63:0] dv;
		x = (HALF_PI_Q30 * 64'(i)) >> tbits;
		x2 = (x * x) >> 30;
		t = Q30_ONE;
		for (int k = 0; k < 6; k++) begin
			unique case (k)
				0: dv = 64'd156;
				1: dv = 64'd110;
				2: dv = 64'd72;
				3: dv = 64'd42;
				4: dv = 64'd20;
				default: dv = 64'd6;
			endcase
			t = Q30_ONE - udiv64((x2 * t) >> 30, dv);
		end
		s = (x * t) >> 30;
		e = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		if (e > 64'd32767) begin
			e = 64'd32767;
		end
		return SINE_W'(e);
	endfunction

endpackage

// File: src/grid_phase_lock_loop_top.sv
// ----------------------------------------------------------------------------
// Grid phase-locked loop
// Synchronous reference frame PLL: Clarke and Park transforms, a PI loop on
// the quadrature voltage, a clamped integrator and a wrapping phase counter.
//
// Usage: the input channel (in_valid, in_stall) carries one item per control
// tick, either a three-phase voltage sample (kind 0) or a restart (kind 1).
// Each item gives exactly one result on the output channel (out_valid,
// out_stall): the new phase, speed, d and q voltages and the lock flag.
// A sample passes through the steps ALPHA, BETA, AC, BS, BC, AS, ROUND, ERR,
// MI, MP, INT, SPD and FIN before its result is registered; a restart goes
// straight to FIN. No new item is taken until the block is idle again. The
// pace is set by the single shared multiplier, which the sequencer uses eight
// times per sample, and by the registered read of the sine ROM.
// While an item is being worked on, in_stall is high. The result waits in an
// output register; if the receiver stalls, the block holds its final step
// until the register is free, and the loop state is updated only then.
// Reset clears the phase to zero, loads the integrator with the default
// initial speed and restores the register defaults. Configuration writes
// take effect at once and should be made while the block is idle.
// ----------------------------------------------------------------------------
module grid_phase_lock_loop_top #(
	parameter int unsigned PHASE_BITS      = gpll_pkg::PHASE_BITS_DEF,
	parameter int unsigned SAMPLE_BITS     = gpll_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned SINE_TABLE_BITS = gpll_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Configuration write port.
	input  logic                                   cfg_we,
	input  logic [gpll_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [gpll_pkg::CFG_DATA_W-1:0]        cfg_data,
	// Input channel.
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   kind,
	input  logic signed [SAMPLE_BITS-1:0]          volt_a,
	input  logic signed [SAMPLE_BITS-1:0]          volt_b,
	input  logic signed [SAMPLE_BITS-1:0]          volt_c,
	// Output channel.
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [PHASE_BITS-1:0]                  phase_angle,
	output logic [gpll_pkg::SPEED_W-1:0]           speed,
	output logic signed [SAMPLE_BITS-1:0]          volt_direct,
	output logic signed [SAMPLE_BITS-1:0]          volt_quad,
	output logic                                   locked
);

	localparam int unsigned SPW     = gpll_pkg::SPEED_W;
	localparam int unsigned TBL_N   = 1 << SINE_TABLE_BITS;
	localparam int unsigned IDX_W   = SINE_TABLE_BITS + 2;
	localparam int unsigned DIFF_W  = SAMPLE_BITS + 2;
	localparam int unsigned ALPHA_W = DIFF_W + 17;
	localparam int unsigned ACC_W   = ALPHA_W + 18;
	localparam int unsigned QR_W    = ACC_W - 30;
	localparam int unsigned MA_W    = (ALPHA_W > 33) ? ALPHA_W : 33;
	localparam int unsigned MB_W    = QR_W;
	localparam int unsigned P_W     = MA_W + MB_W;
	localparam int unsigned SUM_W   = P_W - 15;

	// Sequencer steps.
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ALPHA = 4'd1;
	localparam logic [3:0] ST_BETA  = 4'd2;
	localparam logic [3:0] ST_AC    = 4'd3;
	localparam logic [3:0] ST_BS    = 4'd4;
	localparam logic [3:0] ST_BC    = 4'd5;
	localparam logic [3:0] ST_AS    = 4'd6;
	localparam logic [3:0] ST_ROUND = 4'd7;
	localparam logic [3:0] ST_ERR   = 4'd8;
	localparam logic [3:0] ST_MI    = 4'd9;
	localparam logic [3:0] ST_MP    = 4'd10;
	localparam logic [3:0] ST_INT   = 4'd11;
	localparam logic [3:0] ST_SPD   = 4'd12;
	localparam logic [3:0] ST_FIN   = 4'd13;

	// Quarter-wave sine ROM, built at elaboration.
	typedef logic [gpll_pkg::SINE_W-1:0] rom_t [TBL_N];

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < TBL_N; i++) begin
			r[i] = gpll_pkg::sine_entry(i, SINE_TABLE_BITS);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// Clamp to the speed range; the lower bound wins when the bounds cross.
	function automatic logic [SPW-1:0] clamp_speed(input logic signed [SUM_W-1:0] v,
			input logic [SPW-1:0] mx, input logic [SPW-1:0] mn);
		logic signed [SUM_W-1:0] r;
		r = v;
		if (r > $signed(SUM_W'(mx))) begin
			r = $signed(SUM_W'(mx));
		end
		if (r < $signed(SUM_W'(mn))) begin
			r = $signed(SUM_W'(mn));
		end
		return r[SPW-1:0];
	endfunction

	// Saturate a rounded voltage to the sample range.
	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
			input logic signed [QR_W-1:0] v);
		logic signed [QR_W-1:0] hi;
		logic signed [QR_W-1:0] lo;
		hi = QR_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
		lo = -hi - QR_W'(1);
		if (v > hi) begin
			return hi[SAMPLE_BITS-1:0];
		end
		if (v < lo) begin
			return lo[SAMPLE_BITS-1:0];
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	// Configuration registers.
	logic [gpll_pkg::GAIN_W-1:0] prop_gain_q;
	logic [gpll_pkg::GAIN_W-1:0] integ_gain_q;
	logic [SPW-1:0]              speed_max_q;
	logic [SPW-1:0]              speed_min_q;
	logic [SPW-1:0]              speed_init_q;
	logic [gpll_pkg::QLIM_W-1:0] lock_q_limit_q;
	logic [SPW-1:0]              lock_low_q;
	logic [SPW-1:0]              lock_high_q;

	// Control and loop state.
	logic [3:0]            state_q;
	logic                  restart_q;
	logic                  out_valid_q;
	logic [PHASE_BITS-1:0] phase_acc_q;
	logic [SPW-1:0]        integrator_q;

	// Datapath registers.
	logic signed [DIFF_W-1:0]  diff_a_q;
	logic signed [DIFF_W-1:0]  diff_b_q;
	logic signed [ALPHA_W-1:0] alpha_q;
	logic signed [ALPHA_W-1:0] beta_q;
	logic signed [16:0]        sin_q;
	logic signed [16:0]        cos_q;
	logic signed [ACC_W-1:0]   acc_d_q;
	logic signed [ACC_W-1:0]   acc_q_q;
	logic signed [QR_W-1:0]    d_q;
	logic signed [QR_W-1:0]    q_q;
	logic signed [QR_W-1:0]    err_q;
	logic signed [P_W-1:0]     product_q;
	logic signed [SUM_W-1:0]   integ_sum_q;
	logic [SPW-1:0]            integ_new_q;
	logic signed [SUM_W-1:0]   pterm_q;
	logic signed [SUM_W-1:0]   spd_sum_q;
	logic [gpll_pkg::SINE_W-1:0] rom_q;
	logic                      rd_full_q;
	logic                      rd_neg_q;

	// Output registers.
	logic [PHASE_BITS-1:0]         phase_out_q;
	logic [SPW-1:0]                speed_out_q;
	logic signed [SAMPLE_BITS-1:0] vd_out_q;
	logic signed [SAMPLE_BITS-1:0] vq_out_q;
	logic                          locked_out_q;

	// Combinational signals.
	logic                        in_xfer;
	logic                        out_free;
	logic [IDX_W-1:0]            idx;
	logic [1:0]                  quad;
	logic [SINE_TABLE_BITS:0]    tbl_k;
	logic signed [16:0]          rd_mag;
	logic signed [16:0]          rd_val;
	logic signed [MA_W-1:0]      mul_a;
	logic signed [MB_W-1:0]      mul_b;
	logic signed [ACC_W-1:0]     acc_d_rnd;
	logic signed [ACC_W-1:0]     acc_q_rnd;
	logic signed [P_W-1:0]       prod_rnd;
	logic [SPW-1:0]              spd;
	logic [QR_W-1:0]             abs_q;
	logic                        lock_now;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// Table address: sine while idle, cosine (a quarter turn on) in the next step.
	always_comb begin
		idx = phase_acc_q[PHASE_BITS-1 -: IDX_W];
		quad = idx[IDX_W-1 -: 2] + ((state_q == ST_ALPHA) ? 2'd1 : 2'd0);
		if (quad[0]) begin
			tbl_k = {1'b1, {SINE_TABLE_BITS{1'b0}}} - {1'b0, idx[SINE_TABLE_BITS-1:0]};
		end else begin
			tbl_k = {1'b0, idx[SINE_TABLE_BITS-1:0]};
		end
	end

	// Registered ROM read, with the fold flags of the same read.
	always_ff @(posedge clk) begin
		rom_q <= SINE_ROM[tbl_k[SINE_TABLE_BITS-1:0]];
		rd_full_q <= tbl_k[SINE_TABLE_BITS];
		rd_neg_q <= quad[1];
	end

	// Signed Q15 value of the last table read.
	always_comb begin
		rd_mag = rd_full_q ? gpll_pkg::SINE_FULL : $signed({2'b00, rom_q});
		rd_val = rd_neg_q ? -rd_mag : rd_mag;
	end

	// Shared multiplier operand selection.
	always_comb begin
		unique case (state_q)
			ST_ALPHA: begin
				mul_a = MA_W'(diff_a_q);
				mul_b = MB_W'(gpll_pkg::CLARKE_ALPHA);
			end
			ST_BETA: begin
				mul_a = MA_W'(diff_b_q);
				mul_b = MB_W'(gpll_pkg::CLARKE_BETA);
			end
			ST_AC: begin
				mul_a = MA_W'(alpha_q);
				mul_b = MB_W'(cos_q);
			end
			ST_BS: begin
				mul_a = MA_W'(beta_q);
				mul_b = MB_W'(sin_q);
			end
			ST_BC: begin
				mul_a = MA_W'(beta_q);
				mul_b = MB_W'(cos_q);
			end
			ST_AS: begin
				mul_a = MA_W'(alpha_q);
				mul_b = MB_W'(sin_q);
			end
			ST_MI: begin
				mul_a = MA_W'($signed({1'b0, integ_gain_q}));
				mul_b = err_q;
			end
			ST_MP: begin
				mul_a = MA_W'($signed({1'b0, prop_gain_q}));
				mul_b = err_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Rounding (half up) of the Park sums and of the gain products.
	always_comb begin
		acc_d_rnd = (acc_d_q + (ACC_W'(1) <<< 30)) >>> 31;
		acc_q_rnd = (acc_q_q + (ACC_W'(1) <<< 30)) >>> 31;
		prod_rnd = (product_q + (P_W'(1) <<< 15)) >>> 16;
	end

	// Final speed clamp and lock decision.
	always_comb begin
		spd = clamp_speed(spd_sum_q, speed_max_q, speed_min_q);
		abs_q = q_q[QR_W-1] ? QR_W'(-q_q) : QR_W'(q_q);
		lock_now = (abs_q < QR_W'(lock_q_limit_q)) && (spd > lock_low_q)
			&& (spd < lock_high_q);
	end

	// Datapath registers, stepped by the sequencer.
	always_ff @(posedge clk) begin
		product_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				diff_a_q <= (DIFF_W'(volt_a) <<< 1) - DIFF_W'(volt_b) - DIFF_W'(volt_c);
				diff_b_q <= DIFF_W'(volt_b) - DIFF_W'(volt_c);
			end
			ST_ALPHA: sin_q <= rd_val;
			ST_BETA: begin
				cos_q <= rd_val;
				alpha_q <= ALPHA_W'(product_q);
			end
			ST_AC: beta_q <= ALPHA_W'(product_q);
			ST_BS: acc_d_q <= ACC_W'(product_q);
			ST_BC: acc_d_q <= acc_d_q + ACC_W'(product_q);
			ST_AS: acc_q_q <= ACC_W'(product_q);
			ST_ROUND: acc_q_q <= acc_q_q - ACC_W'(product_q);
			ST_ERR: begin
				d_q <= QR_W'(acc_d_rnd);
				q_q <= QR_W'(acc_q_rnd);
				err_q <= -QR_W'(acc_q_rnd);
			end
			ST_MP: begin
				integ_sum_q <= SUM_W'($signed({1'b0, integrator_q})) + SUM_W'(prod_rnd);
			end
			ST_INT: begin
				integ_new_q <= clamp_speed(integ_sum_q, speed_max_q, speed_min_q);
				pterm_q <= SUM_W'(prod_rnd);
			end
			ST_SPD: spd_sum_q <= pterm_q + SUM_W'($signed({1'b0, integ_new_q}));
			default: begin
			end
		endcase
	end

	// Result register loads when the sequence ends and the register is free.
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			if (restart_q) begin
				phase_out_q <= '0;
				speed_out_q <= speed_init_q;
				vd_out_q <= '0;
				vq_out_q <= '0;
				locked_out_q <= 1'b0;
			end else begin
				phase_out_q <= phase_acc_q + PHASE_BITS'(spd);
				speed_out_q <= spd;
				vd_out_q <= sat_sample(d_q);
				vq_out_q <= sat_sample(q_q);
				locked_out_q <= lock_now;
			end
		end
	end

	assign phase_angle = phase_out_q;
	assign speed       = speed_out_q;
	assign volt_direct = vd_out_q;
	assign volt_quad   = vq_out_q;
	assign locked      = locked_out_q;

	// Sequencer, loop state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			restart_q <= 1'b0;
			out_valid_q <= 1'b0;
			phase_acc_q <= '0;
			integrator_q <= gpll_pkg::SPEED_INITIAL_RST;
		end else begin
			// The result register fills at the final step and empties on a transfer out.
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						restart_q <= kind;
						state_q <= kind ? ST_FIN : ST_ALPHA;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (restart_q) begin
							phase_acc_q <= '0;
							integrator_q <= speed_init_q;
						end else begin
							phase_acc_q <= phase_acc_q + PHASE_BITS'(spd);
							integrator_q <= integ_new_q;
						end
					end
				end
				default: state_q <= state_q + 4'd1;
			endcase
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q <= '0;
			integ_gain_q <= '0;
			speed_max_q <= gpll_pkg::SPEED_MAX_RST;
			speed_min_q <= gpll_pkg::SPEED_MIN_RST;
			speed_init_q <= gpll_pkg::SPEED_INITIAL_RST;
			lock_q_limit_q <= gpll_pkg::LOCK_Q_LIMIT_RST;
			lock_low_q <= gpll_pkg::LOCK_SPEED_LOW_RST;
			lock_high_q <= gpll_pkg::LOCK_SPEED_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gpll_pkg::REG_PROP_GAIN:       prop_gain_q <= cfg_data;
				gpll_pkg::REG_INTEG_GAIN_STEP: integ_gain_q <= cfg_data;
				gpll_pkg::REG_SPEED_MAX:       speed_max_q <= cfg_data[SPW-1:0];
				gpll_pkg::REG_SPEED_MIN:       speed_min_q <= cfg_data[SPW-1:0];
				gpll_pkg::REG_SPEED_INITIAL:   speed_init_q <= cfg_data[SPW-1:0];
				gpll_pkg::REG_LOCK_Q_LIMIT:
					lock_q_limit_q <= cfg_data[gpll_pkg::QLIM_W-1:0];
				gpll_pkg::REG_LOCK_SPEED_LOW:  lock_low_q <= cfg_data[SPW-1:0];
				gpll_pkg::REG_LOCK_SPEED_HIGH: lock_high_q <= cfg_data[SPW-1:0];
				default: begin
				end
			endcase
		end
	end

	// A transfer in starts a sequence, so the input stalls in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input not stalled after a transfer");

	// A locked result always reports a speed inside the lock window.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && locked) |-> (speed > lock_low_q && speed < lock_high_q))
		else $error("lock flag set outside the speed window");

	// A result is only produced by leaving the final step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_FIN && state_q == ST_IDLE))
		else $error("result raised outside the final step");

endmodule
